### hw/rtl/ffha_pkg.sv
// ffha_pkg: shared types and fixed field widths for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int REQ_BYTES_W = 13;
   localparam int OFFSET_W    = 12;

   typedef enum logic [10:0] {
      ST_INIT  = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_RD    = 11'b000_0000_0100,
      ST_LOAD  = 11'b000_0000_1000,
      ST_CHK   = 11'b000_0001_0000,
      ST_ABS   = 11'b000_0010_0000,
      ST_NXT   = 11'b000_0100_0000,
      ST_FIT   = 11'b000_1000_0000,
      ST_SPLIT = 11'b001_0000_0000,
      ST_FEND  = 11'b010_0000_0000,
      ST_RESP  = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic init;       // write root header
      logic accept;     // latch request, restart walk at offset zero
      logic rd_h;       // read header at walk pointer
      logic load_cur;   // capture read header as current block
      logic rd_next;    // read header that follows current block
      logic merge;      // absorb follower into current block
      logic set_free;   // mark current block free
      logic adv;        // walk pointer to next block
      logic wr_merged;  // write current block back as free
      logic wr_taken;   // write current block as allocated, record grant
      logic wr_split;   // write split-off remainder
      logic set_fail;   // report no space
   } dp_cmd_type;

   typedef struct packed {
      logic req_free;     // request port asks for a free
      logic req_null;     // request port offset is null or below a header
      logic mode_free;    // latched request is a free
      logic cur_free;     // current block is free
      logic end_in_heap;  // next block starts inside the heap
      logic at_target;    // walk pointer is the block to free
      logic past_target;  // next block lies beyond the block to free
      logic nxt_free;     // read follower is free
      logic fits;         // current block covers the request
      logic split_ok;     // remainder leaves room for a block
   } dp_status_type;

endpackage

### hw/rtl/ffha_dp.sv
// ffha_dp: header store, walk pointer and block arithmetic of the allocator.
// Driven by ffha_ctrl through ffha_pkg::dp_cmd_type; depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_dp #(
   parameter int HEAP_BYTES   = 4096,
   parameter int HEADER_BYTES = 24,
   parameter int MIN_CAPACITY = 24
) (
   input  logic                                  clock,
   input  ffha_pkg::dp_cmd_type                  cmd,
   output ffha_pkg::dp_status_type               status,
   input  logic                                  req_mode,
   input  logic [ffha_pkg::REQ_BYTES_W-1:0]      req_request_bytes,
   input  logic [ffha_pkg::OFFSET_W-1:0]         req_payload_offset,
   output logic                                  rsp_status,
   output logic [ffha_pkg::OFFSET_W-1:0]         rsp_granted_offset
);

   localparam int AW = $clog2(HEAP_BYTES);
   localparam int CW = AW;
   localparam int EW = CW + 1;
   localparam int PW = ((AW > ffha_pkg::OFFSET_W) ? AW : ffha_pkg::OFFSET_W) + 2;

   localparam logic [PW-1:0] HDR_P  = PW'(HEADER_BYTES);
   localparam logic [PW-1:0] MIN_P  = PW'(MIN_CAPACITY);
   localparam logic [PW-1:0] HEAP_P = PW'(HEAP_BYTES);
   localparam logic [CW-1:0] ROOT_CAP = CW'(HEAP_BYTES - HEADER_BYTES);

   logic [EW-1:0] mem [HEAP_BYTES];
   logic [EW-1:0] rd_data_ff;

   logic [PW-1:0] h_ff, h_in;
   logic [PW-1:0] target_ff, target_in;
   logic [PW-1:0] q_ff, q_in;
   logic [PW-1:0] first_ff, first_in;
   logic [PW-1:0] first_hdr_ff, first_hdr_in;
   logic [PW-1:0] qlim_ff, qlim_in;
   logic [PW-1:0] split_addr_ff, split_addr_in;
   logic [CW-1:0] rest_ff, rest_in;
   logic [CW-1:0] cur_cap_ff, cur_cap_in;
   logic          cur_free_ff, cur_free_in;
   logic          mode_ff, mode_in;
   logic          stat_ff, stat_in;
   logic [ffha_pkg::OFFSET_W-1:0] grant_ff, grant_in;

   logic [PW-1:0] end_w;
   logic [PW-1:0] q_w;
   logic [PW-1:0] p_w;
   logic [PW-1:0] first_w;
   logic [PW-1:0] cap_w;
   logic [PW-1:0] grant_w;
   logic [CW-1:0] rd_cap;
   logic          rd_free;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign rd_cap  = rd_data_ff[CW-1:0];
   assign rd_free = rd_data_ff[CW];
   assign cap_w   = PW'(cur_cap_ff);
   assign end_w   = h_ff + HDR_P + cap_w;
   assign q_w     = PW'(req_request_bytes);
   assign p_w     = PW'(req_payload_offset);
   assign first_w = (q_w > MIN_P) ? q_w : MIN_P;
   assign grant_w = h_ff + HDR_P;

   always_comb begin
      status.req_free    = req_mode;
      status.req_null    = (p_w < HDR_P);
      status.mode_free   = mode_ff;
      status.cur_free    = cur_free_ff;
      status.end_in_heap = (end_w < HEAP_P);
      status.at_target   = (h_ff == target_ff);
      status.past_target = (end_w > target_ff);
      status.nxt_free    = rd_free;
      status.fits        = (cap_w >= q_ff);
      status.split_ok    = (qlim_ff <= cap_w);
   end

   // read port
   always_comb begin
      rd_en   = cmd.rd_h | cmd.rd_next;
      rd_addr = cmd.rd_next ? end_w[AW-1:0] : h_ff[AW-1:0];
   end

   // write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = h_ff[AW-1:0];
      wr_data = {1'b1, cur_cap_ff};
      if (cmd.init) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = {1'b1, ROOT_CAP};
      end else if (cmd.wr_merged) begin
         wr_en   = 1'b1;
      end else if (cmd.wr_taken) begin
         wr_en   = 1'b1;
         wr_data = {1'b0, status.split_ok ? first_ff[CW-1:0] : cur_cap_ff};
      end else if (cmd.wr_split) begin
         wr_en   = (split_addr_ff < HEAP_P);
         wr_addr = split_addr_ff[AW-1:0];
         wr_data = {1'b1, rest_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      h_in          = h_ff;
      target_in     = target_ff;
      q_in          = q_ff;
      first_in      = first_ff;
      first_hdr_in  = first_hdr_ff;
      qlim_in       = qlim_ff;
      split_addr_in = split_addr_ff;
      rest_in       = rest_ff;
      cur_cap_in    = cur_cap_ff;
      cur_free_in   = cur_free_ff;
      mode_in       = mode_ff;
      stat_in       = stat_ff;
      grant_in      = grant_ff;
      if (cmd.accept) begin
         h_in         = '0;
         target_in    = p_w - HDR_P;
         q_in         = q_w;
         first_in     = first_w;
         first_hdr_in = first_w + HDR_P;
         qlim_in      = q_w + HDR_P + MIN_P;
         mode_in      = req_mode;
         stat_in      = 1'b0;
         grant_in     = '0;
      end
      if (cmd.load_cur) begin
         cur_cap_in  = rd_cap;
         cur_free_in = rd_free;
      end
      if (cmd.merge) begin
         cur_cap_in = CW'(cap_w + HDR_P + PW'(rd_cap));
      end
      if (cmd.set_free) begin
         cur_free_in = 1'b1;
      end
      if (cmd.adv) begin
         h_in = end_w;
      end
      if (cmd.wr_taken) begin
         grant_in      = grant_w[ffha_pkg::OFFSET_W-1:0];
         split_addr_in = h_ff + first_hdr_ff;
         rest_in       = CW'(cap_w - first_hdr_ff);
      end
      if (cmd.set_fail) begin
         stat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      h_ff          <= h_in;
      target_ff     <= target_in;
      q_ff          <= q_in;
      first_ff      <= first_in;
      first_hdr_ff  <= first_hdr_in;
      qlim_ff       <= qlim_in;
      split_addr_ff <= split_addr_in;
      rest_ff       <= rest_in;
      cur_cap_ff    <= cur_cap_in;
      cur_free_ff   <= cur_free_in;
      mode_ff       <= mode_in;
      stat_ff       <= stat_in;
      grant_ff      <= grant_in;
   end

   assign rsp_status         = stat_ff;
   assign rsp_granted_offset = grant_ff;

endmodule

### hw/rtl/ffha_ctrl.sv
// ffha_ctrl: state machine that sequences the block walk, coalescing and split.
// Issues ffha_pkg::dp_cmd_type to ffha_dp; depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output logic                      rsp_valid,
   input  ffha_pkg::dp_status_type   status,
   output ffha_pkg::dp_cmd_type      cmd
);

   ffha_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ffha_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ffha_pkg::ST_IDLE;
         end
         ffha_pkg::ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (status.req_free && status.req_null) begin
                  state_in = ffha_pkg::ST_RESP;
               end else begin
                  state_in = ffha_pkg::ST_RD;
               end
            end
         end
         ffha_pkg::ST_RD: begin
            cmd.rd_h = 1'b1;
            state_in = ffha_pkg::ST_LOAD;
         end
         ffha_pkg::ST_LOAD: begin
            cmd.load_cur = 1'b1;
            state_in     = ffha_pkg::ST_CHK;
         end
         ffha_pkg::ST_CHK: begin
            if (status.mode_free) begin
               if (status.at_target) begin
                  cmd.set_free = 1'b1;
                  state_in     = ffha_pkg::ST_ABS;
               end else if (status.end_in_heap && !status.past_target) begin
                  cmd.adv  = 1'b1;
                  state_in = ffha_pkg::ST_RD;
               end else begin
                  state_in = ffha_pkg::ST_RESP;
               end
            end else if (status.cur_free) begin
               state_in = ffha_pkg::ST_ABS;
            end else if (status.end_in_heap) begin
               cmd.adv  = 1'b1;
               state_in = ffha_pkg::ST_RD;
            end else begin
               cmd.set_fail = 1'b1;
               state_in     = ffha_pkg::ST_RESP;
            end
         end
         ffha_pkg::ST_ABS: begin
            if (status.end_in_heap) begin
               cmd.rd_next = 1'b1;
               state_in    = ffha_pkg::ST_NXT;
            end else if (status.mode_free) begin
               state_in = ffha_pkg::ST_FEND;
            end else begin
               state_in = ffha_pkg::ST_FIT;
            end
         end
         ffha_pkg::ST_NXT: begin
            if (status.nxt_free) begin
               cmd.merge = 1'b1;
               state_in  = ffha_pkg::ST_ABS;
            end else if (status.mode_free) begin
               state_in = ffha_pkg::ST_FEND;
            end else begin
               state_in = ffha_pkg::ST_FIT;
            end
         end
         ffha_pkg::ST_FIT: begin
            if (status.fits) begin
               cmd.wr_taken = 1'b1;
               state_in = status.split_ok ? ffha_pkg::ST_SPLIT : ffha_pkg::ST_RESP;
            end else begin
               cmd.wr_merged = 1'b1;
               if (status.end_in_heap) begin
                  cmd.adv  = 1'b1;
                  state_in = ffha_pkg::ST_RD;
               end else begin
                  cmd.set_fail = 1'b1;
                  state_in     = ffha_pkg::ST_RESP;
               end
            end
         end
         ffha_pkg::ST_SPLIT: begin
            cmd.wr_split = 1'b1;
            state_in     = ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_FEND: begin
            cmd.wr_merged = 1'b1;
            state_in      = ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_RESP: begin
            state_in = ffha_pkg::ST_IDLE;
         end
         default: begin
            state_in = ffha_pkg::ST_INIT;
         end
      endcase
   end

   assign busy      = (state_ff != ffha_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ffha_pkg::ST_RESP);

endmodule

### hw/rtl/first_fit_heap_allocator_top.sv
// first_fit_heap_allocator_top: first-fit allocator with forward coalescing.
// Each visited block is read, loaded and checked; free followers are read and absorbed until a
// used one or the heap end; then fit or write back, split if room, respond. A null free
// responds in the cycle after acceptance. One request at a time, busy until the strobe passes.
// Reset: synchronous; root header written during reset and the first cycle after (busy high).
// Responses appear for one cycle on rsp_valid; the receiver cannot stall them.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top #(
   parameter int HEAP_BYTES   = 4096,
   parameter int HEADER_BYTES = 24,
   parameter int MIN_CAPACITY = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_mode,
   input  logic [ffha_pkg::REQ_BYTES_W-1:0]      req_request_bytes,
   input  logic [ffha_pkg::OFFSET_W-1:0]         req_payload_offset,
   output logic                                  rsp_valid,
   output logic                                  rsp_status,
   output logic [ffha_pkg::OFFSET_W-1:0]         rsp_granted_offset
);

   ffha_pkg::dp_cmd_type    cmd;
   ffha_pkg::dp_status_type status;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   ffha_dp #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MIN_CAPACITY (MIN_CAPACITY)
   ) u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_request_bytes  (req_request_bytes),
      .req_payload_offset (req_payload_offset),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset)
   );

endmodule

### hw/rtl/ffha_checker.sv
// ffha_port_checks: port-level checks of the allocator's request/response sequencing.
// Bound to first_fit_heap_allocator_top; depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_port_checks (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_status,
   input logic [ffha_pkg::OFFSET_W-1:0]    rsp_granted_offset
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response not a single cycle followed by idle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_granted_offset == '0))
      else $error("failed allocate reports nonzero offset");

endmodule

bind first_fit_heap_allocator_top ffha_port_checks u_ffha_port_checks (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_granted_offset (rsp_granted_offset)
);

### dv/ffha_tb_pkg.sv
// ffha_tb_pkg: request and response codes shared by the allocator testbench files.
// Used by ffha_checker and tb_first_fit_heap_allocator_top; depends on nothing.
`timescale 1ns / 1ps

package ffha_tb_pkg;

   localparam bit MODE_ALLOC = 1'b0;
   localparam bit MODE_FREE  = 1'b1;

   localparam bit STATUS_DONE     = 1'b0;
   localparam bit STATUS_NO_SPACE = 1'b1;

endpackage

### dv/ffha_checker.sv
// ffha_checker: watches the request and response ports of the first-fit allocator,
// keeps its own copy of the heap headers and compares every response in order.
// Depends on ffha_pkg (port widths) and ffha_tb_pkg (request and status codes).
`timescale 1ns / 1ps

module ffha_checker #(
   parameter int HEAP_BYTES   = 4096,
   parameter int HEADER_BYTES = 24,
   parameter int MIN_CAPACITY = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_mode,
   input  logic [ffha_pkg::REQ_BYTES_W-1:0] req_request_bytes,
   input  logic [ffha_pkg::OFFSET_W-1:0]    req_payload_offset,
   input  logic                             rsp_valid,
   input  logic                             rsp_status,
   input  logic [ffha_pkg::OFFSET_W-1:0]    rsp_granted_offset,
   output int                               fault_count,
   output int                               outstanding
);

   typedef struct packed {
      bit        is_free;
      bit [30:0] cap;
   } blk_hdr_type;

   typedef struct packed {
      bit                            status;
      bit [ffha_pkg::OFFSET_W-1:0]   offset;
   } grant_type;

   blk_hdr_type heap_hdr [HEAP_BYTES];
   grant_type   awaited_grants [$];
   int          faults;

   assign fault_count = faults;

   function automatic int unsigned block_end(int unsigned h);
      return h + HEADER_BYTES + heap_hdr[h].cap;
   endfunction

   function automatic void clear_heap();
      for (int i = 0; i < HEAP_BYTES; i++) heap_hdr[i] = '0;
      heap_hdr[0] = '{1'b1, 31'(HEAP_BYTES - HEADER_BYTES)};
   endfunction

   function automatic void merge_followers(int unsigned h);
      int unsigned n;
      forever begin
         n = block_end(h);
         if (n >= HEAP_BYTES || !heap_hdr[n].is_free) return;
         heap_hdr[h] = '{1'b1, 31'(heap_hdr[h].cap + HEADER_BYTES + heap_hdr[n].cap)};
      end
   endfunction

   function automatic int unsigned place_request(int unsigned q, output bit ok);
      int unsigned h, cap, first, n;
      h = 0;
      ok = 1'b0;
      while (h < HEAP_BYTES) begin
         if (heap_hdr[h].is_free) begin
            merge_followers(h);
            cap = heap_hdr[h].cap;
            if (cap >= q) begin
               if (q + HEADER_BYTES + MIN_CAPACITY <= cap) begin
                  first = (q > MIN_CAPACITY) ? q : MIN_CAPACITY;
                  n = h + HEADER_BYTES + first;
                  heap_hdr[h] = '{1'b0, 31'(first)};
                  if (n < HEAP_BYTES)
                     heap_hdr[n] = '{1'b1, 31'(cap - first - HEADER_BYTES)};
               end else begin
                  heap_hdr[h] = '{1'b0, 31'(cap)};
               end
               ok = 1'b1;
               return h + HEADER_BYTES;
            end
         end
         h = block_end(h);
      end
      return 0;
   endfunction

   function automatic void release_block(int unsigned p);
      int unsigned target, h;
      if (p < HEADER_BYTES) return;
      target = p - HEADER_BYTES;
      h = 0;
      while (h < HEAP_BYTES && h <= target) begin
         if (h == target) begin
            heap_hdr[h].is_free = 1'b1;
            merge_followers(h);
            return;
         end
         h = block_end(h);
      end
   endfunction

   function automatic grant_type predict_grant(bit mode, int unsigned nbytes, int unsigned p);
      grant_type g;
      bit ok;
      int unsigned off;
      g = '0;
      if (mode == ffha_tb_pkg::MODE_ALLOC) begin
         off = place_request(nbytes, ok);
         g.status = ok ? ffha_tb_pkg::STATUS_DONE : ffha_tb_pkg::STATUS_NO_SPACE;
         g.offset = off[ffha_pkg::OFFSET_W-1:0];
      end else begin
         release_block(p);
         g.status = ffha_tb_pkg::STATUS_DONE;
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         clear_heap();
         awaited_grants.delete();
         faults = 0;
         outstanding <= 0;
      end else begin
         if (start && !busy)
            awaited_grants.push_back(predict_grant(req_mode, req_request_bytes,
                                                   req_payload_offset));
         if (rsp_valid) begin
            if (awaited_grants.size() == 0) begin
               if (faults < 10)
                  $display("%0t: unexpected response status=%0d offset=%0d",
                           $realtime, rsp_status, rsp_granted_offset);
               faults++;
            end else begin
               want = awaited_grants.pop_front();
               if (want.status !== rsp_status || want.offset !== rsp_granted_offset) begin
                  if (faults < 10)
                     $display("%0t: mismatch status exp=%0d got=%0d, offset exp=%0d got=%0d",
                              $realtime, want.status, rsp_status, want.offset,
                              rsp_granted_offset);
                  faults++;
               end
            end
         end
         outstanding <= awaited_grants.size();
      end
   end

endmodule

### dv/tb_first_fit_heap_allocator_top.sv
// tb_first_fit_heap_allocator_top: drives directed and random allocate/free requests
// into first_fit_heap_allocator_top and reports the verdict from ffha_checker.
// Depends on ffha_pkg, ffha_tb_pkg, ffha_checker and the allocator RTL.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_top;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic                             req_mode = ffha_tb_pkg::MODE_ALLOC;
   logic [ffha_pkg::REQ_BYTES_W-1:0] req_request_bytes = '0;
   logic [ffha_pkg::OFFSET_W-1:0]    req_payload_offset = '0;
   logic                             rsp_valid;
   logic                             rsp_status;
   logic [ffha_pkg::OFFSET_W-1:0]    rsp_granted_offset;
   int                               fault_count;
   int                               outstanding;

   int unsigned live_blocks [$];
   int          idle_pct;

   always #4 clock = ~clock;

   first_fit_heap_allocator_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_request_bytes  (req_request_bytes),
      .req_payload_offset (req_payload_offset),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset)
   );

   ffha_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_request_bytes  (req_request_bytes),
      .req_payload_offset (req_payload_offset),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .fault_count        (fault_count),
      .outstanding        (outstanding)
   );

   // granted blocks, sampled mid-cycle, feed the free requests
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_status == ffha_tb_pkg::STATUS_DONE &&
          rsp_granted_offset != 0)
         live_blocks.push_back(rsp_granted_offset);
   end

   task automatic send_request(input bit m, input int unsigned nbytes, input int unsigned off);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_mode           <= m;
      req_request_bytes  <= nbytes[ffha_pkg::REQ_BYTES_W-1:0];
      req_payload_offset <= off[ffha_pkg::OFFSET_W-1:0];
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_pause();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic int unsigned pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(0, 64);
      if (r < 90) return $urandom_range(65, 600);
      if (r < 98) return $urandom_range(601, 4072);
      return $urandom_range(4073, 4096);
   endfunction

   initial begin
      int r, idx;
      int unsigned off;
      idle_pct = 9;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: null and bogus frees, double free, coalescing to whole heap, exact fits
      send_request(ffha_tb_pkg::MODE_ALLOC, 0, 4095);
      send_request(ffha_tb_pkg::MODE_ALLOC, 24, 0);
      send_request(ffha_tb_pkg::MODE_ALLOC, 100, 0);
      send_request(ffha_tb_pkg::MODE_ALLOC, 4096, 0);
      send_request(ffha_tb_pkg::MODE_FREE, 8191, 0);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 5);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 4095);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 100);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 72);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 72);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 24);
      send_request(ffha_tb_pkg::MODE_ALLOC, 72, 0);
      send_request(ffha_tb_pkg::MODE_ALLOC, 0, 0);
      send_request(ffha_tb_pkg::MODE_ALLOC, 3804, 0);
      send_request(ffha_tb_pkg::MODE_ALLOC, 0, 0);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 120);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 292);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 244);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 24);
      send_request(ffha_tb_pkg::MODE_ALLOC, 4072, 0);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 24);
      send_request(ffha_tb_pkg::MODE_ALLOC, 4025, 0);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 24);
      send_request(ffha_tb_pkg::MODE_ALLOC, 4024, 0);
      send_request(ffha_tb_pkg::MODE_FREE, 0, 24);
      drain_pause();
      live_blocks.delete();

      for (int i = 0; i < 1500; i++) begin
         if (i == 500) begin
            idle_pct = 68;
            drain_pause();
         end
         if (i == 1000) begin
            idle_pct = 0;
            drain_pause();
         end
         r = $urandom_range(99);
         if (r < 55 || (r < 92 && live_blocks.size() == 0)) begin
            send_request(ffha_tb_pkg::MODE_ALLOC, pick_size(), $urandom_range(0, 4095));
         end else if (r < 92) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            off = live_blocks[idx];
            if ($urandom_range(9) != 0) live_blocks.delete(idx);
            send_request(ffha_tb_pkg::MODE_FREE, $urandom_range(0, 4096), off);
         end else if (r < 96 || live_blocks.size() == 0) begin
            send_request(ffha_tb_pkg::MODE_FREE, $urandom_range(0, 4096),
                         $urandom_range(0, 4095));
         end else begin
            off = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_request(ffha_tb_pkg::MODE_FREE, $urandom_range(0, 4096),
                         off + $urandom_range(1, 30) - 15);
         end
      end
      start <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
      if (fault_count == 0 && outstanding == 0) begin
         $display("first_fit_heap_allocator_top test passed");
      end else begin
         $display("first_fit_heap_allocator_top test failed");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("first_fit_heap_allocator_top test failed");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_dp.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_top.sv
hw/rtl/ffha_checker.sv
dv/ffha_tb_pkg.sv
dv/ffha_checker.sv
dv/tb_first_fit_heap_allocator_top.sv
